// ----- hw/rtl/fce_pkg.sv -----
// fce_pkg: shared widths, register indexes, item operations, command codes,
// controller states and the control/status structs of the lighting channel fade engine.
// No dependencies.
package fce_pkg;

    // field widths
    localparam int LEVEL_W    = 17;
    localparam int DUR_W      = 22;
    localparam int CMD_W      = 3;
    localparam int INC_W      = LEVEL_W + 1;
    localparam int ACC_W      = LEVEL_W + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCENE_TARGET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCANNER_MODE = 1'd1;

    // item operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // fade commands
    localparam logic [CMD_W-1:0] CMD_BLACK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FADEIN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FADEOUT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FADETO  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IDLE    = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_DIST,
        ST_COMMIT
    } fce_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_start;
        logic quot_capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_go;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

// ----- hw/rtl/fce_divider.sv -----
// fce_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on fce_pkg for the operand width.
module fce_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fce_pkg::DUR_W-1:0] dividend,
    input  logic [fce_pkg::DUR_W-1:0] divisor,
    output logic [fce_pkg::DUR_W-1:0] quotient,
    output logic                      done
);
    import fce_pkg::*;

    localparam int CNT_W = $clog2(DUR_W);

    logic [DUR_W-1:0] rem_reg;
    logic [DUR_W-1:0] quo_reg;
    logic [DUR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DUR_W:0]   shifted;
    logic [DUR_W:0]   trial;
    logic             fits;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DUR_W-1]};
        trial   = shifted - {1'b0, dvsr_reg};
        fits    = !trial[DUR_W];
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DUR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DUR_W-1:0] : shifted[DUR_W-1:0];
            quo_reg <= {quo_reg[DUR_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- hw/rtl/fce_datapath.sv -----
// fce_datapath: per-line fade state, config registers, start evaluation,
// tick update, step division and the output register.
// Depends on fce_pkg and fce_divider.
module fce_datapath #(
    parameter int TICK_MS        = 10,
    parameter int MIX_LINE_COUNT = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           operation,
    input  logic                           mix_line,
    input  logic [fce_pkg::CMD_W-1:0]      command,
    input  logic [fce_pkg::DUR_W-1:0]      duration_ms,
    input  logic [fce_pkg::LEVEL_W-1:0]    fade_to_level,
    input  logic                           out_stall,
    input  fce_pkg::ctrl_cmd_t             cmd,
    output fce_pkg::ctrl_status_t          status,
    output logic                           out_valid,
    output logic                           running,
    output logic [fce_pkg::LEVEL_W-1:0]    level,
    output logic                           level_changed
);
    import fce_pkg::*;

    localparam int LINE_IDX_W = (MIX_LINE_COUNT > 1) ? $clog2(MIX_LINE_COUNT) : 1;

    // reciprocal of the tick period, exact floor for every duration
    localparam int          RECIP_SHIFT = DUR_W + $clog2(TICK_MS);
    localparam int          RECIP_W     = DUR_W + 2;
    localparam int          PROD_W      = DUR_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL  =
        ((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [RECIP_W-1:0] TICK_RECIP = RECIP_FULL[RECIP_W-1:0];

    // configuration
    logic [LEVEL_W-1:0] scene_reg;
    logic               scanner_reg;

    // per-line state
    logic [LEVEL_W-1:0]      line_level_reg [MIX_LINE_COUNT];
    logic [LEVEL_W-1:0]      line_goal_reg  [MIX_LINE_COUNT];
    logic signed [INC_W-1:0] line_inc_reg   [MIX_LINE_COUNT];
    logic [CMD_W-1:0]        line_cmd_reg   [MIX_LINE_COUNT];

    // captured item
    logic               op_reg;
    logic               line_reg;
    logic [CMD_W-1:0]   code_reg;
    logic [LEVEL_W-1:0] to_level_reg;

    // start evaluation and division results
    logic                    start_ok_reg;
    logic [LEVEL_W-1:0]      goal_reg;
    logic signed [INC_W-1:0] dist_reg;
    logic [DUR_W-1:0]        ticks_reg;
    logic [LEVEL_W-1:0]      quot_reg;

    // output beat
    logic               out_valid_reg;
    logic               running_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               changed_reg;

    logic                    line_ok;
    logic [LINE_IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0]      cur;
    logic [LEVEL_W-1:0]      line_goal;
    logic signed [INC_W-1:0] line_inc;
    logic [CMD_W-1:0]        line_cmd;

    logic                    start_ok;
    logic [LEVEL_W-1:0]      start_goal;
    logic signed [INC_W-1:0] start_dist;

    logic [PROD_W-1:0]       ticks_prod;
    logic [PROD_W-1:0]       ticks_shift;
    logic [DUR_W-1:0]        ticks_calc;

    logic [INC_W-1:0]        dist_neg;
    logic [LEVEL_W-1:0]      dist_mag;
    logic [DUR_W-1:0]        div_dividend;
    logic [DUR_W-1:0]        div_divisor;
    logic [DUR_W-1:0]        div_quotient;
    logic                    div_done;
    logic signed [INC_W-1:0] start_inc;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] goal_ext;
    logic                    fade_active;
    logic                    fade_finish;
    logic [LEVEL_W-1:0]      snap_level;
    logic [LEVEL_W-1:0]      tick_level;

    logic                    line_we;
    logic [LEVEL_W-1:0]      level_next;
    logic [LEVEL_W-1:0]      goal_next;
    logic signed [INC_W-1:0] inc_next;
    logic [CMD_W-1:0]        act_next;
    logic                    running_next;
    logic [LEVEL_W-1:0]      out_level_next;
    logic                    changed_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scene_reg   <= '0;
            scanner_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCENE_TARGET: scene_reg   <= cfg_data[LEVEL_W-1:0];
                REG_SCANNER_MODE: scanner_reg <= cfg_data[0];
                default:          scene_reg   <= scene_reg;
            endcase
        end
    end

    // tick count of the duration by reciprocal multiply
    always_comb
    begin
        ticks_prod  = PROD_W'(duration_ms) * PROD_W'(TICK_RECIP);
        ticks_shift = ticks_prod >> RECIP_SHIFT;
        ticks_calc  = ticks_shift[DUR_W-1:0];
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            line_reg     <= mix_line;
            code_reg     <= command;
            ticks_reg    <= ticks_calc;
            to_level_reg <= fade_to_level;
        end
    end

    // addressed line state
    always_comb
    begin
        line_ok   = (32'(line_reg) < 32'(MIX_LINE_COUNT));
        idx       = line_ok ? LINE_IDX_W'(line_reg) : '0;
        cur       = line_level_reg[idx];
        line_goal = line_goal_reg[idx];
        line_inc  = line_inc_reg[idx];
        line_cmd  = line_cmd_reg[idx];
    end

    // start acceptance and goal selection
    always_comb
    begin
        start_ok   = 1'b0;
        start_goal = '0;
        if (scanner_reg)
        begin
            start_ok   = (code_reg inside {CMD_FADEIN, CMD_FADETO}) && (cur != scene_reg);
            start_goal = scene_reg;
        end
        else
        begin
            case (code_reg)
                CMD_BLACK, CMD_FADEOUT:
                begin
                    start_ok   = (cur != '0);
                    start_goal = '0;
                end
                CMD_FADEIN:
                begin
                    start_ok   = (cur < scene_reg);
                    start_goal = scene_reg;
                end
                CMD_FADETO:
                begin
                    start_ok   = (cur != to_level_reg);
                    start_goal = to_level_reg;
                end
                default:
                begin
                    start_ok   = 1'b0;
                    start_goal = '0;
                end
            endcase
        end
        start_dist = $signed({1'b0, start_goal}) - $signed({1'b0, cur});
    end

    assign status.start_go = line_ok && (op_reg == OP_START) && start_ok;

    // evaluation registers
    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            start_ok_reg <= status.start_go;
            goal_reg     <= start_goal;
            dist_reg     <= start_dist;
        end
        if (cmd.quot_capture)
        begin
            quot_reg <= div_quotient[LEVEL_W-1:0];
        end
    end

    // divider operands: distance magnitude over ticks
    always_comb
    begin
        dist_neg     = -start_dist;
        dist_mag     = start_dist[INC_W-1] ? dist_neg[LEVEL_W-1:0] : start_dist[LEVEL_W-1:0];
        div_dividend = DUR_W'(dist_mag);
        div_divisor  = ticks_reg;
    end

    fce_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;

    // signed step, whole distance when under one tick
    always_comb
    begin
        if (ticks_reg == '0)
        begin
            start_inc = dist_reg;
        end
        else if (dist_reg[INC_W-1])
        begin
            start_inc = -$signed({1'b0, quot_reg});
        end
        else
        begin
            start_inc = $signed({1'b0, quot_reg});
        end
    end

    // tick update and end-of-fade check
    always_comb
    begin
        acc         = $signed({2'b00, cur}) + $signed({line_inc[INC_W-1], line_inc});
        goal_ext    = $signed({2'b00, line_goal});
        fade_active = (line_cmd <= CMD_FADETO);
        case (line_cmd)
            CMD_BLACK, CMD_FADEOUT:
            begin
                fade_finish = (acc <= 0);
                snap_level  = '0;
            end
            CMD_FADEIN:
            begin
                fade_finish = (acc >= goal_ext);
                snap_level  = scene_reg;
            end
            default:
            begin
                fade_finish = ((line_inc > 0) && (acc >= goal_ext))
                           || ((line_inc < 0) && (acc <= goal_ext));
                snap_level  = line_goal;
            end
        endcase
        tick_level = fade_finish ? snap_level : acc[LEVEL_W-1:0];
    end

    // result and line state update
    always_comb
    begin
        line_we        = 1'b0;
        level_next     = cur;
        goal_next      = line_goal;
        inc_next       = line_inc;
        act_next       = line_cmd;
        running_next   = 1'b0;
        out_level_next = cur;
        changed_next   = 1'b0;
        if (!line_ok)
        begin
            out_level_next = '0;
        end
        else if (op_reg == OP_TICK)
        begin
            if (fade_active)
            begin
                line_we        = 1'b1;
                level_next     = tick_level;
                act_next       = fade_finish ? CMD_IDLE : line_cmd;
                running_next   = !fade_finish;
                out_level_next = tick_level;
                changed_next   = (tick_level != cur);
            end
        end
        else if (start_ok_reg)
        begin
            line_we      = 1'b1;
            goal_next    = goal_reg;
            inc_next     = start_inc;
            act_next     = code_reg;
            running_next = 1'b1;
        end
    end

    // per-line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MIX_LINE_COUNT; i++)
            begin
                line_level_reg[i] <= '0;
                line_goal_reg[i]  <= '0;
                line_inc_reg[i]   <= '0;
                line_cmd_reg[i]   <= CMD_IDLE;
            end
        end
        else if (cmd.commit && line_we)
        begin
            line_level_reg[idx] <= level_next;
            line_goal_reg[idx]  <= goal_next;
            line_inc_reg[idx]   <= inc_next;
            line_cmd_reg[idx]   <= act_next;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            running_reg <= running_next;
            level_reg   <= out_level_next;
            changed_reg <= changed_next;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign running         = running_reg;
    assign level           = level_reg;
    assign level_changed   = changed_reg;

endmodule

// ----- hw/rtl/fce_ctrl.sv -----
// fce_ctrl: controller state machine sequencing capture, evaluation,
// the step division and commit. Depends on fce_pkg.
module fce_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  fce_pkg::ctrl_status_t status,
    output logic                  in_stall,
    output fce_pkg::ctrl_cmd_t    cmd
);
    import fce_pkg::*;

    fce_state_t state_reg;
    fce_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = status.start_go ? ST_DIV_DIST : ST_COMMIT;
            end
            ST_DIV_DIST:
            begin
                if (status.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval      = 1'b1;
                cmd.div_start = status.start_go;
            end
            ST_DIV_DIST:
            begin
                cmd.quot_capture = status.div_done;
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lighting_channel_fade_engine.sv -----
// lighting_channel_fade_engine: linear fade ramp generator for one level per mix line.
// Ticks and rejected starts: captured, evaluated and committed to the output register.
// Starts that begin a fade also wait on the 22-step restoring divider (distance over ticks)
// before commit; a stalled output holds the commit. No new item is taken until commit.
// Reset clears all levels, steps and goals, idles every fade and zeroes the config.
// Depends on fce_pkg, fce_ctrl, fce_datapath.
module lighting_channel_fade_engine #(
    parameter int TICK_MS        = 10,
    parameter int MIX_LINE_COUNT = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic                           mix_line,
    input  logic [fce_pkg::CMD_W-1:0]      command,
    input  logic [fce_pkg::DUR_W-1:0]      duration_ms,
    input  logic [fce_pkg::LEVEL_W-1:0]    fade_to_level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           running,
    output logic [fce_pkg::LEVEL_W-1:0]    level,
    output logic                           level_changed
);
    import fce_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencing
    fce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // state, arithmetic and output beat
    fce_datapath #(
        .TICK_MS        (TICK_MS),
        .MIX_LINE_COUNT (MIX_LINE_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .mix_line      (mix_line),
        .command       (command),
        .duration_ms   (duration_ms),
        .fade_to_level (fade_to_level),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .running       (running),
        .level         (level),
        .level_changed (level_changed)
    );

endmodule
